>>> sv/compass_heading_defines.svh
// Assertion macros used by the compass heading top level.
`ifndef COMPASS_HEADING_DEFINES_SVH
`define COMPASS_HEADING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ch_pkg.sv
// Types, widths and constants of the compass heading block.
package ch_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int HEADING_W        = 16;
    localparam int XY_W             = 35;
    localparam int Z_W              = 25;
    localparam int H_W              = 18;
    localparam int ANGLE_TABLE_LEN  = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [Z_W-1:0] QUARTER_FINE = 25'sd2949120;
    localparam logic signed [H_W-1:0] FULL_TURN    = 18'sd46080;

    // atan(2^-i) in units of 1/32768 degree.
    localparam logic signed [Z_W-1:0] ATAN_FINE [ANGLE_TABLE_LEN] = '{
        25'sd1474560, 25'sd870484, 25'sd459940, 25'sd233473,
        25'sd117189,  25'sd58652,  25'sd29333,  25'sd14667,
        25'sd7334,    25'sd3667,   25'sd1833,   25'sd917,
        25'sd458,     25'sd229,    25'sd115,    25'sd57,
        25'sd29,      25'sd14,     25'sd7,      25'sd4,
        25'sd2,       25'sd1,      25'sd0,      25'sd0
    };

    typedef struct packed {
        logic signed [XY_W-1:0] cx;
        logic signed [XY_W-1:0] cy;
        logic signed [Z_W-1:0]  z;
        logic                   zero;
    } cordic_t;

endpackage

>>> sv/ch_ifs.sv
// Handshake interfaces for samples, headings and the declination write.
interface ch_sample_if;
    import ch_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    modport source (output valid, output x_sample, output y_sample, input ready);
    modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

interface ch_heading_if;
    import ch_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [HEADING_W-1:0] heading;
    modport source (output valid, output heading, input ready);
    modport sink   (input valid, input heading, output ready);
endinterface

interface ch_cfg_if;
    import ch_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] declination;
    modport source (output valid, output declination, input ready);
    modport sink   (input valid, input declination, output ready);
endinterface

>>> sv/ch_pre.sv
// Input stage: scales a sample and turns the left half plane into the right one.
module ch_pre (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               up_valid,
    input  logic signed [ch_pkg::SAMPLE_W-1:0] x_sample,
    input  logic signed [ch_pkg::SAMPLE_W-1:0] y_sample,
    output logic                               up_ready,
    input  logic                               down_ready,
    output logic                               valid_reg,
    output ch_pkg::cordic_t                    data_reg
);
    import ch_pkg::*;

    logic                   valid_next;
    cordic_t                data_next;
    logic signed [XY_W-1:0] cx0;
    logic signed [XY_W-1:0] cy0;

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        cx0 = {{(XY_W-2*SAMPLE_W){x_sample[SAMPLE_W-1]}}, x_sample, {SAMPLE_W{1'b0}}};
        cy0 = {{(XY_W-2*SAMPLE_W){y_sample[SAMPLE_W-1]}}, y_sample, {SAMPLE_W{1'b0}}};
        data_next.zero = (x_sample == '0) && (y_sample == '0);
        if (!x_sample[SAMPLE_W-1])
        begin
            data_next.cx = cx0;
            data_next.cy = cy0;
            data_next.z  = '0;
        end
        else if (!y_sample[SAMPLE_W-1])
        begin
            data_next.cx = cy0;
            data_next.cy = -cx0;
            data_next.z  = QUARTER_FINE;
        end
        else
        begin
            data_next.cx = -cy0;
            data_next.cy = cx0;
            data_next.z  = -QUARTER_FINE;
        end
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> sv/ch_cordic_cell.sv
// One CORDIC vectoring step with a fixed shift, registered.
module ch_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    input  ch_pkg::cordic_t up_data,
    output logic            up_ready,
    input  logic            down_ready,
    output logic            valid_reg,
    output ch_pkg::cordic_t data_reg
);
    import ch_pkg::*;

    logic                   valid_next;
    cordic_t                data_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic                   rot_neg;

    assign up_ready = !valid_reg || down_ready;

    always_comb
    begin
        dx      = up_data.cy >>> SHIFT;
        dy      = up_data.cx >>> SHIFT;
        rot_neg = !up_data.cy[XY_W-1];
        data_next.zero = up_data.zero;
        if (rot_neg)
        begin
            data_next.cx = up_data.cx + dx;
            data_next.cy = up_data.cy - dy;
            data_next.z  = up_data.z + ATAN_FINE[SHIFT];
        end
        else
        begin
            data_next.cx = up_data.cx - dx;
            data_next.cy = up_data.cy + dy;
            data_next.z  = up_data.z - ATAN_FINE[SHIFT];
        end
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

>>> sv/ch_post.sv
// Output stages: rounding, declination add, wrap to one turn and saturation.
module ch_post (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               up_valid,
    input  ch_pkg::cordic_t                    up_data,
    input  logic signed [ch_pkg::SAMPLE_W-1:0] declination,
    output logic                               up_ready,
    input  logic                               down_ready,
    output logic                               out_valid,
    output logic [ch_pkg::HEADING_W-1:0]       heading
);
    import ch_pkg::*;

    logic                        sum_valid_reg;
    logic                        sum_valid_next;
    logic signed [H_W-1:0]       sum_reg;
    logic signed [H_W-1:0]       sum_next;
    logic                        head_valid_reg;
    logic                        head_valid_next;
    logic [HEADING_W-1:0]        head_reg;
    logic [HEADING_W-1:0]        head_next;
    logic                        sum_ready;
    logic signed [Z_W-1:0]       z_round;
    logic signed [Z_W-9:0]       angle;
    logic signed [H_W-1:0]       wrapped;

    assign sum_ready = !head_valid_reg || down_ready;
    assign up_ready  = !sum_valid_reg || sum_ready;
    assign out_valid = head_valid_reg;
    assign heading   = head_reg;

    // Round the fine angle to 1/128 degree; the zero vector reads as 0.
    always_comb
    begin
        z_round  = up_data.z + Z_W'(128);
        angle    = up_data.zero ? '0 : z_round[Z_W-1:8];
        sum_next = H_W'(angle) + H_W'(declination);
        sum_valid_next = up_ready ? up_valid : sum_valid_reg;
    end

    always_comb
    begin
        if (sum_reg < 0)
        begin
            wrapped = sum_reg + FULL_TURN;
        end
        else if (sum_reg > FULL_TURN)
        begin
            wrapped = sum_reg - FULL_TURN;
        end
        else
        begin
            wrapped = sum_reg;
        end
        if (wrapped < 0)
        begin
            head_next = '0;
        end
        else if (wrapped > FULL_TURN)
        begin
            head_next = HEADING_W'(FULL_TURN);
        end
        else
        begin
            head_next = wrapped[HEADING_W-1:0];
        end
        head_valid_next = sum_ready ? sum_valid_reg : head_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg  <= 1'b0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg  <= sum_valid_next;
            head_valid_reg <= head_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            sum_reg <= sum_next;
        end
        if (sum_valid_reg && sum_ready)
        begin
            head_reg <= head_next;
        end
    end

endmodule

>>> sv/compass_heading.sv
// Compass heading top level: CORDIC atan2 cell chain plus declination and wrap.
//
//   channel  role  beat payload
//   -------  ----  -----------------------------------------------
//   sample   sink  x_sample, y_sample (signed 16 bit raw readings)
//   result   src   heading (unsigned 16 bit, 1/128 degree, 0..46080)
//   cfg      sink  declination (signed 16 bit, 1/128 degree)
//
// One sample is accepted per cycle unless every stage is full and the result is
// stalled; a heading passes one input stage, one cell per CORDIC step and two
// output stages. Every stage holds its own valid bit, so bubbles close up and a
// stalled result only stops new samples once every stage is full. Reset empties
// the pipeline and sets the declination to 0. cfg is always ready.
module compass_heading #(
    parameter int CORDIC_STEPS = ch_pkg::CORDIC_STEPS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    ch_sample_if.sink       sample,
    ch_heading_if.source    result,
    ch_cfg_if.sink          cfg
);
    import ch_pkg::*;
    `include "compass_heading_defines.svh"

    logic                       stage_valid [CORDIC_STEPS+1];
    cordic_t                    stage_data  [CORDIC_STEPS+1];
    logic                       take        [CORDIC_STEPS+2];
    logic signed [SAMPLE_W-1:0] decl_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= '0;
        end
        else if (cfg.valid)
        begin
            decl_reg <= cfg.declination;
        end
    end

    ch_pre u_pre (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (sample.valid),
        .x_sample   (sample.x_sample),
        .y_sample   (sample.y_sample),
        .up_ready   (take[0]),
        .down_ready (take[1]),
        .valid_reg  (stage_valid[0]),
        .data_reg   (stage_data[0])
    );

    assign sample.ready = take[0];

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cell
        ch_cordic_cell #(
            .SHIFT (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (stage_valid[k]),
            .up_data    (stage_data[k]),
            .up_ready   (take[k+1]),
            .down_ready (take[k+2]),
            .valid_reg  (stage_valid[k+1]),
            .data_reg   (stage_data[k+1])
        );
    end

    ch_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (stage_valid[CORDIC_STEPS]),
        .up_data     (stage_data[CORDIC_STEPS]),
        .declination (decl_reg),
        .up_ready    (take[CORDIC_STEPS+1]),
        .down_ready  (result.ready),
        .out_valid   (result.valid),
        .heading     (result.heading)
    );

    `CH_ASSERT_IMPL(a_heading_range, clk, rst_n, result.valid,
        result.heading <= HEADING_W'(FULL_TURN), "heading beyond one full turn")
    `CH_ASSERT_IMPL(a_stall_only_when_blocked, clk, rst_n, !sample.ready,
        result.valid && !result.ready, "sample stalled while the output drains")
    `CH_ASSERT_NEXT(a_decl_written, clk, rst_n, cfg.valid && cfg.ready,
        decl_reg == $past(cfg.declination), "declination write lost")

endmodule

>>> verif/compass_heading_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the compass heading block with its own CORDIC heading predictor.
module compass_heading_test;
    import ch_pkg::*;

    localparam int    STEPS    = 16;
    localparam int    ARC_LEN  = 24;
    localparam longint TURN    = 46080;
    localparam longint QUARTER = 2949120;
    localparam int    LATENCY  = STEPS + 3;

    // atan(2^-i) in 1/32768 degree.
    localparam longint ARC_TABLE [ARC_LEN] = '{
        1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
        7334, 3667, 1833, 917, 458, 229, 115, 57,
        29, 14, 7, 4, 2, 1, 0, 0
    };

    typedef enum int {RX_ALWAYS, RX_RANDOM_RUNS} rx_mode_t;

    typedef logic signed [SAMPLE_W-1:0] axis_t;

    logic clk;
    logic rst_n;

    ch_sample_if  smp();
    ch_heading_if res();
    ch_cfg_if     cfg_ch();

    compass_heading #(.CORDIC_STEPS(STEPS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfg_ch)
    );

    logic [HEADING_W-1:0] heading_due[$];
    axis_t    decl_now;
    rx_mode_t rx_mode;
    int       hold_cycles;
    bit       gaps_on;
    bit       offering;
    int       burst_left;
    int       mismatches;
    int       items_sent;
    int       headings_seen;
    int       decl_writes;
    int       floor_hits;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d headings still pending", heading_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [HEADING_W-1:0] predict_heading(axis_t x, axis_t y, axis_t decl);
        longint cx, cy, arc, t, dx, dy, h;
        cx = longint'(x) * 65536;
        cy = longint'(y) * 65536;
        arc = 0;
        if (x == 0 && y == 0)
        begin
            h = 0;
        end
        else
        begin
            // Fold the left half plane into the right one by a quarter turn.
            if (cx < 0)
            begin
                t = cx;
                if (cy >= 0)
                begin
                    cx = cy;
                    cy = -t;
                    arc = QUARTER;
                end
                else
                begin
                    cx = -cy;
                    cy = t;
                    arc = -QUARTER;
                end
            end
            for (int i = 0; i < STEPS && i < ARC_LEN; i++)
            begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0)
                begin
                    cx += dx;
                    cy -= dy;
                    arc += ARC_TABLE[i];
                end
                else
                begin
                    cx -= dx;
                    cy += dy;
                    arc -= ARC_TABLE[i];
                end
            end
            h = (arc + 128) >>> 8;
        end
        h = h + longint'(decl);
        if (h < 0)
            h += TURN;
        else if (h > TURN)
            h -= TURN;
        if (h < 0)
            h = 0;
        if (h > TURN)
            h = TURN;
        return h[HEADING_W-1:0];
    endfunction

    function automatic axis_t random_axis();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            1: return axis_t'($urandom_range(0, 8)) - 16'sd4;
            2: return '0;
            default: return axis_t'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Each accepted result beat is compared with the oldest pending heading.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            headings_seen++;
            if (heading_due.size() == 0)
                report_mismatch("heading with none pending", res.heading, -1);
            else if (res.heading !== heading_due[0])
                report_mismatch("heading", res.heading, heading_due.pop_front());
            else
                void'(heading_due.pop_front());
        end
    end

    // Receiver: always ready, or random runs of ready and stall, with an occasional long hold-off.
    initial
    begin
        int run_left;
        bit run_ready;
        run_left = 0;
        run_ready = 1'b1;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                res.ready <= 1'b0;
            end
            else if (rx_mode == RX_ALWAYS)
            begin
                res.ready <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_ready = ($urandom_range(0, 99) < 65);
                    run_left = $urandom_range(1, 8);
                end
                run_left--;
                res.ready <= run_ready;
            end
        end
    end

    task automatic send_sample(axis_t x, axis_t y);
        smp.valid    <= 1'b1;
        smp.x_sample <= x;
        smp.y_sample <= y;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!smp.ready);
        heading_due.push_back(predict_heading(x, y, decl_now));
        items_sent++;
        if (predict_heading(x, y, decl_now) == 0 && decl_now < -23040)
            floor_hits++;
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                smp.valid <= 1'b0;
                offering = 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(1, 4))
                    @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic pause_until_drained();
        if (offering)
        begin
            smp.valid <= 1'b0;
            offering = 1'b0;
            @(posedge clk);
        end
        while (heading_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_declination(axis_t value);
        pause_until_drained();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.declination <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        decl_now = value;
        decl_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_axis_extremes();
        axis_t pts [18][2] = '{
            '{16'sd0, 16'sd0},             '{16'sh7FFF, 16'sd0},
            '{16'sh8000, 16'sd0},          '{16'sd0, 16'sh7FFF},
            '{16'sd0, 16'sh8000},          '{16'sh8000, 16'sh8000},
            '{16'sh7FFF, 16'sh7FFF},       '{16'sh8000, 16'sh7FFF},
            '{16'sh7FFF, 16'sh8000},       '{-16'sd1, 16'sd0},
            '{-16'sd5, 16'sd0},            '{16'sd1, 16'sd1},
            '{-16'sd1, -16'sd1},           '{16'sd1, 16'sd0},
            '{16'sd0, 16'sd1},             '{-16'sd1, 16'sd1},
            '{16'sd1, -16'sd1},            '{16'sd0, -16'sd1}
        };
        rx_mode = RX_ALWAYS;
        gaps_on = 1'b0;
        // The declination stays at its reset value here.
        foreach (pts[i])
            send_sample(pts[i][0], pts[i][1]);
        pause_until_drained();
    endtask

    task automatic check_declination_settings();
        axis_t settings [7] = '{16'sd23040, -16'sd23040, 16'sh7FFF, 16'sh8000,
                                16'sd1, -16'sd1, 16'sd0};
        rx_mode = RX_RANDOM_RUNS;
        gaps_on = 1'b1;
        foreach (settings[s])
        begin
            write_declination(settings[s]);
            repeat (40)
                send_sample(random_axis(), random_axis());
        end
    endtask

    task automatic check_full_pipeline_stall();
        write_declination(axis_t'($urandom_range(0, 46080)) - 16'sd23040);
        rx_mode = RX_RANDOM_RUNS;
        gaps_on = 1'b0;
        // Hold the result side long enough that every stage fills and the
        // sample side has to stall.
        hold_cycles = 4 * LATENCY;
        repeat (60)
            send_sample(random_axis(), random_axis());
        pause_until_drained();
    endtask

    task automatic check_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 3)
                write_declination(axis_t'($urandom));
            else
                write_declination(axis_t'($urandom_range(0, 46080)) - 16'sd23040);
            rx_mode = (phase == 1) ? RX_ALWAYS : RX_RANDOM_RUNS;
            gaps_on = (phase != 2);
            repeat (110)
                send_sample(random_axis(), random_axis());
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        smp.valid          <= 1'b0;
        smp.x_sample       <= '0;
        smp.y_sample       <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.declination <= '0;
        decl_now      = '0;
        rx_mode       = RX_ALWAYS;
        hold_cycles   = 0;
        gaps_on       = 1'b0;
        offering      = 1'b0;
        burst_left    = 1;
        mismatches    = 0;
        items_sent    = 0;
        headings_seen = 0;
        decl_writes   = 0;
        floor_hits    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_axis_extremes();
        check_declination_settings();
        check_full_pipeline_stall();
        check_random_traffic();

        pause_until_drained();
        repeat (LATENCY + 8) @(posedge clk);

        $display("Sent %0d samples under %0d declination writes; %0d headings compared.",
                 items_sent, decl_writes, headings_seen);
        $display("Samples clamped to zero heading by a far-out declination: %0d.", floor_hits);
        if (mismatches == 0 && heading_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
